// ===== rtl/sorted_key_table_macros.svh =====
// Assertion macros for the sorted key table.
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SKT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/skt_pkg.sv =====
// Types, codes and constants shared by the sorted key table modules.
`default_nettype none

package skt_pkg;

    localparam int SKT_CAPACITY = 64;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] key;
        logic [31:0]        entry_handle;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [31:0] handle_out;
        logic [1:0]  status;
        logic [6:0]  entry_count;
    } t_rsp;

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/skt_ctrl.sv =====
// Request sequencer: capture/compare cycle, then update/result cycle.
`default_nettype none

module skt_ctrl
    import skt_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                // closed while reset is held
                o_in_ready    = i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
            end
            S_UPDATE: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/skt_dp.sv =====
// Cell chain of sorted key/handle pairs with compare flags and result register.
`default_nettype none

module skt_dp
    import skt_pkg::*;
#(
    parameter int CAPACITY = SKT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire  t_req i_req,
    input  wire  t_cmd i_cmd,
    output t_sts       o_sts,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_rsp       o_out_data
);

    logic signed [31:0] r_key [CAPACITY];
    logic [31:0]        r_hdl [CAPACITY];
    logic [CAPACITY-1:0] r_valid;
    logic [CAPACITY-1:0] r_less;
    logic [CAPACITY-1:0] r_eq;
    logic [CNT_W-1:0]    r_count;
    t_req                r_req;
    t_rsp                r_rsp;
    logic                r_out_valid;

    logic             found;
    logic             full;
    logic             do_add;
    logic             do_rem;
    logic [31:0]      hsel;
    logic [CNT_W-1:0] n_count;
    t_rsp             n_rsp;

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_rsp;

    // Per-cell compare against the incoming key, taken at the input transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
            for (int i = 0; i < CAPACITY; i++) begin
                r_less[i] <= r_valid[i] && (r_key[i] < i_req.key);
                r_eq[i]   <= r_valid[i] && (r_key[i] == i_req.key);
            end
        end
    end

    // Handle of the matching cell; at most one flag is set.
    always_comb begin
        hsel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hsel = hsel | (r_hdl[i] & {32{r_eq[i]}});
        end
    end

    assign found = |r_eq;
    assign full  = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        do_add           = 1'b0;
        do_rem           = 1'b0;
        n_count          = r_count;
        n_rsp.found      = found;
        n_rsp.handle_out = '0;
        n_rsp.status     = ST_OK;
        unique case (r_req.mode)
            MODE_ADD: begin
                if (found) begin
                    n_rsp.status = ST_DUP;
                end else if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    do_add  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            MODE_REMOVE: begin
                if (!found) begin
                    n_rsp.status = ST_MISSING;
                end else begin
                    do_rem  = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
            MODE_LOOKUP: begin
                if (found) begin
                    n_rsp.handle_out = hsel;
                end else begin
                    n_rsp.status = ST_MISSING;
                end
            end
            default: begin
                // unused mode: table untouched
                n_rsp.status = ST_OK;
            end
        endcase
        n_rsp.entry_count = 7'(n_count);
    end

    // Cells at or above the insert/remove point move one slot.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_cmd.commit && do_add && !r_less[g]) begin
                if (g == 0) begin
                    r_key[g] <= r_req.key;
                    r_hdl[g] <= r_req.entry_handle;
                end else if (r_less[(g == 0) ? 0 : g-1]) begin
                    r_key[g] <= r_req.key;
                    r_hdl[g] <= r_req.entry_handle;
                end else begin
                    r_key[g] <= r_key[(g == 0) ? 0 : g-1];
                    r_hdl[g] <= r_hdl[(g == 0) ? 0 : g-1];
                end
            end else if (i_cmd.commit && do_rem && !r_less[g] && (g < CAPACITY-1)) begin
                r_key[g] <= r_key[(g < CAPACITY-1) ? g+1 : g];
                r_hdl[g] <= r_hdl[(g < CAPACITY-1) ? g+1 : g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
                if (do_add) begin
                    r_valid <= {r_valid[CAPACITY-2:0], 1'b1};
                end else if (do_rem) begin
                    r_valid <= {1'b0, r_valid[CAPACITY-1:1]};
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_key_table.sv =====
// Top level of the sorted key table: sequencer plus cell-chain datapath.
//
//  channel   direction   handshake                    payload
//  request   in          i_in_valid / o_in_ready      i_in_data  (t_req)
//  result    out         o_out_valid / i_out_ready    o_out_data (t_rsp)
//
// Each request is handled in order: the transfer registers a compare flag in
// every cell, then the update state shifts the chain and loads the result register.
// One request is in flight at a time; a result waiting in the output register
// holds the update cycle until it is taken.
// Reset (i_rst_n low, synchronous) empties the table; no clearing pass.
`default_nettype none

`include "sorted_key_table_macros.svh"

module sorted_key_table
    import skt_pkg::*;
#(
    parameter int CAPACITY = SKT_CAPACITY
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_data,
    output logic      o_out_valid,
    input  wire       i_out_ready,
    output t_rsp      o_out_data
);

    // Count must hold CAPACITY itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_cmd cmd;
    t_sts sts;

    skt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    skt_dp #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // One request at a time: after a transfer the input closes until the update is done.
    `SKT_ASSERT_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready, "second request taken while busy")

    // Held entries never exceed the table size.
    `SKT_ASSERT_NOW(a_count_bound, o_out_valid, o_out_data.entry_count <= CAPACITY, "entry count above capacity")

    // A refused add for lack of room is always for a new key.
    `SKT_ASSERT_NOW(a_full_new_key, o_out_valid && (o_out_data.status == ST_FULL), !o_out_data.found, "full status on a present key")

    // A nonzero handle only comes with a successful lookup.
    `SKT_ASSERT_NOW(a_handle_found, o_out_valid && (o_out_data.handle_out != 32'd0), o_out_data.found && (o_out_data.status == ST_OK), "handle on a miss")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the sorted key table: directed rows, then random phases.
`default_nettype none

module tb_top;
    import skt_pkg::*;

    // Mode value that the block has to ignore
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_CYCLES = 20;

    typedef enum {
        PH_FILL,
        PH_MIX,
        PH_DRAIN
    } t_phase;

    // One row of the directed part; want is used only where typed is set
    typedef struct {
        t_req req;
        bit   typed;
        t_rsp want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_req i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out_data;

    // Shadow copy of the table, updated in transfer order
    logic signed [31:0] tbl_key [SKT_CAPACITY];
    logic [31:0]        tbl_handle [SKT_CAPACITY];
    int                 tbl_count = 0;

    t_rsp     pending_rsp [$];
    t_dir_row dir_rows [$];
    t_rsp     got_want;
    int       mismatches = 0;

    sorted_key_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one request to the shadow table and return the result it should give.
    // Lower-bound search over the occupied slots, signed key order.
    function automatic t_rsp table_apply(t_req r);
        int   lo;
        int   hi;
        int   mid;
        int   i;
        bit   present;
        t_rsp rsp;
        lo = 0;
        hi = tbl_count;
        while (hi > lo) begin
            mid = (lo + hi) / 2;
            if ($signed(tbl_key[mid]) < $signed(r.key)) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        present = (lo < tbl_count) && (tbl_key[lo] == r.key);
        rsp = '0;
        rsp.found = present;
        rsp.status = ST_OK;
        case (r.mode)
            MODE_ADD: begin
                // duplicate wins over full
                if (present) begin
                    rsp.status = ST_DUP;
                end else if (tbl_count >= SKT_CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (i = tbl_count; i > lo; i--) begin
                        tbl_key[i] = tbl_key[i - 1];
                        tbl_handle[i] = tbl_handle[i - 1];
                    end
                    tbl_key[lo] = r.key;
                    tbl_handle[lo] = r.entry_handle;
                    tbl_count++;
                end
            end
            MODE_REMOVE: begin
                if (!present) begin
                    rsp.status = ST_MISSING;
                end else begin
                    tbl_count--;
                    for (i = lo; i < tbl_count; i++) begin
                        tbl_key[i] = tbl_key[i + 1];
                        tbl_handle[i] = tbl_handle[i + 1];
                    end
                end
            end
            MODE_LOOKUP: begin
                if (present) begin
                    rsp.handle_out = tbl_handle[lo];
                end else begin
                    rsp.status = ST_MISSING;
                end
            end
            default: begin
                // unused mode: table untouched, presence still reported
            end
        endcase
        rsp.entry_count = 7'(tbl_count);
        return rsp;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Key choice: fresh 32-bit value, a key held now, or a small pool near zero
    // and the extremes, so that hits, misses and ordering at the ends all occur.
    function automatic logic signed [31:0] pick_key(int fresh_pct, int held_pct);
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < fresh_pct) return $urandom;
        if (r < fresh_pct + held_pct && tbl_count > 0)
            return tbl_key[$urandom_range(0, tbl_count - 1)];
        s = $urandom_range(0, 131);
        case (s)
            128:     return KEY_MIN;
            129:     return KEY_MIN + 1;
            130:     return KEY_MAX;
            131:     return KEY_MAX - 1;
            default: return s - 64;
        endcase
    endfunction

    function automatic t_req random_req(t_phase kind);
        int   r;
        int   add_pct;
        int   rem_pct;
        int   look_pct;
        int   fresh_pct;
        int   held_pct;
        t_req req;
        case (kind)
            PH_FILL: begin
                add_pct = 80; rem_pct = 5; look_pct = 12; fresh_pct = 60; held_pct = 10;
            end
            PH_DRAIN: begin
                add_pct = 8; rem_pct = 75; look_pct = 14; fresh_pct = 5; held_pct = 80;
            end
            default: begin
                add_pct = 35; rem_pct = 30; look_pct = 30; fresh_pct = 25; held_pct = 40;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < add_pct) begin
            req.mode = MODE_ADD;
        end else if (r < add_pct + rem_pct) begin
            req.mode = MODE_REMOVE;
        end else if (r < add_pct + rem_pct + look_pct) begin
            req.mode = MODE_LOOKUP;
        end else begin
            req.mode = MODE_UNUSED;
        end
        req.key = pick_key(fresh_pct, held_pct);
        case ($urandom_range(0, 9))
            0:       req.entry_handle = '0;
            1:       req.entry_handle = '1;
            default: req.entry_handle = $urandom;
        endcase
        return req;
    endfunction

    function automatic t_dir_row dir_row(logic [1:0] mode, logic signed [31:0] key,
                                         logic [31:0] handle, bit typed, logic found,
                                         logic [31:0] hout, logic [1:0] status,
                                         logic [6:0] count);
        t_dir_row row;
        row.req.mode = mode;
        row.req.key = key;
        row.req.entry_handle = handle;
        row.typed = typed;
        row.want.found = found;
        row.want.handle_out = hout;
        row.want.status = status;
        row.want.entry_count = count;
        return row;
    endfunction

    // Present one request and hold it until the transfer; the prediction is
    // queued at the transfer edge, so queue order is transfer order.
    task automatic send_req(t_req req, bit typed, t_rsp want, bit no_gaps);
        int   gap;
        t_rsp predicted;
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = table_apply(req);
        pending_rsp.push_back(typed ? want : predicted);
        gap = no_gaps ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sender holds off until every queued result has come back
    task automatic hold_until_drained();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
        end
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    // Request side: directed rows, then random phases, then the final wait
    initial begin
        int     sent;
        int     phase_no;
        int     len;
        int     j;
        bit     burst;
        t_phase kind;

        // Empty table first: misses and the ignored mode
        dir_rows.push_back(dir_row(MODE_LOOKUP, 0, 32'h1234_5678, 1, 0, 0, ST_MISSING, 0));
        dir_rows.push_back(dir_row(MODE_REMOVE, KEY_MIN, 0, 1, 0, 0, ST_MISSING, 0));
        dir_rows.push_back(dir_row(MODE_UNUSED, KEY_MAX, '1, 1, 0, 0, ST_OK, 0));
        // Both key extremes, handle extremes, duplicate refused
        dir_rows.push_back(dir_row(MODE_ADD, KEY_MIN, '1, 1, 0, 0, ST_OK, 1));
        dir_rows.push_back(dir_row(MODE_ADD, KEY_MAX, '0, 1, 0, 0, ST_OK, 2));
        dir_rows.push_back(dir_row(MODE_ADD, KEY_MIN, 32'h0000_1234, 1, 1, 0, ST_DUP, 2));
        dir_rows.push_back(dir_row(MODE_LOOKUP, KEY_MIN, 0, 1, 1, '1, ST_OK, 2));
        dir_rows.push_back(dir_row(MODE_LOOKUP, KEY_MAX, '1, 1, 1, '0, ST_OK, 2));
        dir_rows.push_back(dir_row(MODE_UNUSED, KEY_MIN, '1, 1, 1, 0, ST_OK, 2));
        // Inserts into the middle and next to the ends
        dir_rows.push_back(dir_row(MODE_ADD, 0, 32'haaaa_5555, 0, 0, 0, ST_OK, 0));
        dir_rows.push_back(dir_row(MODE_ADD, -1, 32'h5555_aaaa, 0, 0, 0, ST_OK, 0));
        dir_rows.push_back(dir_row(MODE_ADD, 1, 32'h0000_ffff, 0, 0, 0, ST_OK, 0));
        dir_rows.push_back(dir_row(MODE_ADD, KEY_MIN + 1, 32'hffff_0000, 0, 0, 0, ST_OK, 0));
        dir_rows.push_back(dir_row(MODE_ADD, KEY_MAX - 1, 32'h8000_0001, 0, 0, 0, ST_OK, 0));
        dir_rows.push_back(dir_row(MODE_LOOKUP, -1, 0, 0, 0, 0, ST_OK, 0));
        dir_rows.push_back(dir_row(MODE_LOOKUP, 2, 0, 1, 0, 0, ST_MISSING, 7));
        // Removes: middle, repeated, lowest, highest
        dir_rows.push_back(dir_row(MODE_REMOVE, 0, '1, 1, 1, 0, ST_OK, 6));
        dir_rows.push_back(dir_row(MODE_REMOVE, 0, 0, 1, 0, 0, ST_MISSING, 6));
        dir_rows.push_back(dir_row(MODE_LOOKUP, 1, 0, 0, 0, 0, ST_OK, 0));
        dir_rows.push_back(dir_row(MODE_REMOVE, KEY_MIN, 0, 1, 1, 0, ST_OK, 5));
        dir_rows.push_back(dir_row(MODE_REMOVE, KEY_MAX, 0, 1, 1, 0, ST_OK, 4));
        dir_rows.push_back(dir_row(MODE_LOOKUP, KEY_MIN + 1, 0, 0, 0, 0, ST_OK, 0));
        dir_rows.push_back(dir_row(MODE_ADD, 32'sh4000_0000, 32'h3c3c_c3c3, 0, 0, 0, ST_OK, 0));
        dir_rows.push_back(dir_row(MODE_UNUSED, 5, '1, 1, 0, 0, ST_OK, 5));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            send_req(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].want, 1'b0);
        end
        hold_until_drained();

        // Fill to the top (full refusals), mix, drain to empty, mix, repeat
        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase_no % 4)
                0:       kind = PH_FILL;
                2:       kind = PH_DRAIN;
                default: kind = PH_MIX;
            endcase
            len = (kind == PH_MIX) ? $urandom_range(40, 150) : 120;
            burst = ($urandom_range(0, 3) == 0);
            for (j = 0; j < len && sent < RANDOM_ITEMS; j++) begin
                send_req(random_req(kind), 1'b0, '0, burst);
                sent++;
            end
            if (phase_no == 0 || $urandom_range(0, 2) == 0) begin
                hold_until_drained();
            end
            phase_no++;
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side back-pressure: ready runs broken by stalls of random length
    initial begin
        int stall;
        forever begin
            @(posedge i_clk) i_out_ready <= 1'b1;
            repeat ($urandom_range(0, 12)) @(posedge i_clk);
            stall = idle_len();
            if (stall > 0) begin
                @(posedge i_clk) i_out_ready <= 1'b0;
                repeat (stall - 1) @(posedge i_clk);
            end
        end
    end

    // Result checker: every transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("result transfer with no request outstanding");
                mismatches++;
            end else begin
                got_want = pending_rsp.pop_front();
                if (o_out_data.found !== got_want.found) begin
                    $error("found: expected %0d, got %0d", got_want.found,
                           o_out_data.found);
                    mismatches++;
                end
                if (o_out_data.handle_out !== got_want.handle_out) begin
                    $error("handle_out: expected %h, got %h", got_want.handle_out,
                           o_out_data.handle_out);
                    mismatches++;
                end
                if (o_out_data.status !== got_want.status) begin
                    $error("status: expected %0d, got %0d", got_want.status,
                           o_out_data.status);
                    mismatches++;
                end
                if (o_out_data.entry_count !== got_want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d", got_want.entry_count,
                           o_out_data.entry_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
